// ===== sv/deq_pkg.sv =====
// Package for the double-ended queue: operation and status codes,
// fixed field widths and the memory control group. No dependencies.
package deq_pkg;

  localparam int MODE_BITS   = 2;
  localparam int STATUS_BITS = 2;
  localparam int VALUE_BITS  = 32;
  localparam int EXT_BITS    = 64;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_PUSH_BACK  = 2'd0,
    MODE_PUSH_FRONT = 2'd1,
    MODE_POP_FRONT  = 2'd2,
    MODE_POP_BACK   = 2'd3
  } mode_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } ram_ctl_t;

endpackage

// ===== sv/deq_ifs.sv =====
// Channel interfaces of the double-ended queue: operation request and result.
// Depends on deq_pkg for the field widths.
interface deq_req_if
  import deq_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [MODE_BITS-1:0]  mode;
  logic [VALUE_BITS-1:0] push_value;

  modport source (output valid, mode, push_value, input ready);
  modport sink   (input valid, mode, push_value, output ready);
endinterface

interface deq_rsp_if
  import deq_pkg::*;
  #(parameter int COUNT_BITS = 5)
  ();
  logic                   valid;
  logic                   ready;
  logic [STATUS_BITS-1:0] status;
  logic [VALUE_BITS-1:0]  popped_value;
  logic [COUNT_BITS-1:0]  entry_count;

  modport source (output valid, status, popped_value, entry_count, input ready);
  modport sink   (input valid, status, popped_value, entry_count, output ready);
endinterface

// ===== sv/deq_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/deq_ctrl.sv =====
// Ring pointer control of the double-ended queue: front and back indices,
// occupancy, status decision and memory access request. Depends on deq_pkg.
module deq_ctrl
  import deq_pkg::*;
#(
  parameter int CAPACITY  = 16,
  parameter int WORD_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            accept,
  input  mode_t                           mode,
  input  logic [WORD_BITS-1:0]            word,
  output ram_ctl_t                        ram_ctl,
  output logic [$clog2(CAPACITY)-1:0]     waddr,
  output logic [$clog2(CAPACITY)-1:0]     raddr,
  output logic [WORD_BITS-1:0]            wdata,
  output status_t                         status,
  output logic [$clog2(CAPACITY+1)-1:0]   count
);

  localparam int IDX_BITS = $clog2(CAPACITY);
  localparam int CNT_BITS = $clog2(CAPACITY + 1);
  localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(CAPACITY - 1);
  localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(CAPACITY);

  logic [IDX_BITS-1:0] front_index, front_index_next;
  logic [IDX_BITS-1:0] back_index, back_index_next;
  logic [CNT_BITS-1:0] occupancy, occupancy_next;
  logic [IDX_BITS-1:0] front_prev, front_succ, back_prev, back_succ;

  assign front_prev = (front_index == '0) ? LAST_IDX : front_index - IDX_BITS'(1);
  assign front_succ = (front_index == LAST_IDX) ? '0 : front_index + IDX_BITS'(1);
  assign back_prev  = (back_index == '0) ? LAST_IDX : back_index - IDX_BITS'(1);
  assign back_succ  = (back_index == LAST_IDX) ? '0 : back_index + IDX_BITS'(1);

  always_comb begin
    front_index_next = front_index;
    back_index_next  = back_index;
    occupancy_next   = occupancy;
    ram_ctl          = '0;
    waddr            = back_index;
    raddr            = front_index;
    wdata            = word;
    status           = ST_DONE;
    case (mode)
      MODE_PUSH_BACK: begin
        if (occupancy == FULL_CNT) begin
          status = ST_FULL;
        end else begin
          ram_ctl.wr_en   = accept;
          waddr           = back_index;
          back_index_next = back_succ;
          occupancy_next  = occupancy + CNT_BITS'(1);
        end
      end
      MODE_PUSH_FRONT: begin
        if (occupancy == FULL_CNT) begin
          status = ST_FULL;
        end else begin
          ram_ctl.wr_en    = accept;
          waddr            = front_prev;
          front_index_next = front_prev;
          occupancy_next   = occupancy + CNT_BITS'(1);
        end
      end
      MODE_POP_FRONT: begin
        if (occupancy == '0) begin
          status = ST_EMPTY;
        end else begin
          ram_ctl.rd_en    = accept;
          raddr            = front_index;
          front_index_next = front_succ;
          occupancy_next   = occupancy - CNT_BITS'(1);
        end
      end
      MODE_POP_BACK: begin
        if (occupancy == '0) begin
          status = ST_EMPTY;
        end else begin
          ram_ctl.rd_en   = accept;
          raddr           = back_prev;
          back_index_next = back_prev;
          occupancy_next  = occupancy - CNT_BITS'(1);
        end
      end
      default: begin
        status = ST_DONE;
      end
    endcase
  end

  assign count = occupancy_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      front_index <= '0;
      back_index  <= '0;
      occupancy   <= '0;
    end else if (accept) begin
      front_index <= front_index_next;
      back_index  <= back_index_next;
      occupancy   <= occupancy_next;
    end
  end

endmodule

// ===== sv/double_ended_queue.sv =====
// Double-ended queue of data words kept in a ring buffer.
// Depends on deq_pkg, deq_ifs (deq_req_if, deq_rsp_if), deq_ram and deq_ctrl.
//
// Usage:
//   The req channel carries one operation per transfer: mode selects push at
//   the back, push at the front, pop from the front or pop from the back, and
//   push_value is the word a push stores (cut to WORD_BITS; ignored by pops).
//   Every operation returns exactly one transfer on the rsp channel: status
//   (done, refused because full, refused because empty), popped_value (the
//   word a successful pop removed, zero otherwise) and entry_count, the number
//   of entries held after the operation. Results leave in operation order.
//
// Pipeline and throughput:
//   After its request transfer, a result passes the registered read of the entry
//   memory and then the result register. The block takes one operation per
//   cycle unless a stalled result holds it off; each operation makes at most one
//   access to the one-write, one-read memory, so a pop that follows a push of
//   the same entry reads it after the write has landed.
//
// Reset and stalls:
//   The synchronous reset empties the queue (both indices and the occupancy go
//   to zero) and drops every pending result; memory contents are not cleared.
//   While the receiver holds rsp.ready low, the result register keeps its
//   transfer, one more operation may enter the read stage, and req.ready then
//   falls until the result register drains.
module double_ended_queue
  import deq_pkg::*;
#(
  parameter int CAPACITY  = 16,
  parameter int WORD_BITS = 32
) (
  input logic        clk,
  input logic        rst,
  deq_req_if.sink    req,
  deq_rsp_if.source  rsp
);

  localparam int IDX_BITS = $clog2(CAPACITY);
  localparam int CNT_BITS = $clog2(CAPACITY + 1);

  logic                 accept;
  logic                 s1_advance;
  ram_ctl_t             ram_ctl;
  logic [IDX_BITS-1:0]  waddr, raddr;
  logic [WORD_BITS-1:0] word, wdata, rdata;
  status_t              op_status;
  logic [CNT_BITS-1:0]  op_count;
  logic [EXT_BITS-1:0]  push_wide, pop_wide;

  // Read stage: holds the operation while its memory read is in flight.
  logic                 s1_valid;
  logic                 s1_pop;
  status_t              s1_status;
  logic [CNT_BITS-1:0]  s1_count;

  // Result register.
  logic                  out_valid;
  status_t               out_status;
  logic [VALUE_BITS-1:0] out_value;
  logic [CNT_BITS-1:0]   out_count;

  assign s1_advance = s1_valid && (!out_valid || rsp.ready);
  assign req.ready  = !s1_valid || s1_advance;
  assign accept     = req.valid && req.ready;

  assign push_wide = EXT_BITS'(req.push_value);
  assign word      = push_wide[WORD_BITS-1:0];

  deq_ctrl #(
    .CAPACITY  (CAPACITY),
    .WORD_BITS (WORD_BITS)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .mode    (mode_t'(req.mode)),
    .word    (word),
    .ram_ctl (ram_ctl),
    .waddr   (waddr),
    .raddr   (raddr),
    .wdata   (wdata),
    .status  (op_status),
    .count   (op_count)
  );

  deq_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .wr_en (ram_ctl.wr_en),
    .waddr (waddr),
    .wdata (wdata),
    .rd_en (ram_ctl.rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  // The read data register only loads on a read, and a new read is issued
  // only when the read stage is moving on, so rdata stays put while stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pop    <= ram_ctl.rd_en;
      s1_status <= op_status;
      s1_count  <= op_count;
    end
  end

  assign pop_wide = EXT_BITS'(rdata);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || rsp.ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_status <= s1_status;
      out_value  <= s1_pop ? pop_wide[VALUE_BITS-1:0] : '0;
      out_count  <= s1_count;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.popped_value = out_value;
  assign rsp.entry_count  = out_count;

endmodule

// ===== sv/deq_checker.sv =====
// Port-level checker for the double-ended queue and its bind to the top level.
// Depends on deq_pkg and the double_ended_queue port list.
module deq_checker
  import deq_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           rsp_valid,
  input logic                           rsp_ready,
  input logic [STATUS_BITS-1:0]         rsp_status,
  input logic [VALUE_BITS-1:0]          rsp_popped_value,
  input logic [$clog2(CAPACITY+1)-1:0]  rsp_entry_count
);

  localparam int CNT_BITS = $clog2(CAPACITY + 1);

  // A stalled result transfer keeps its contents.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
      && $stable(rsp_popped_value) && $stable(rsp_entry_count))
    else $error("stalled result changed");

  // The count never goes past the capacity.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_entry_count <= CNT_BITS'(CAPACITY))
    else $error("entry count beyond capacity");

  // A refused push is only reported on a full queue, a refused pop on an empty one.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == ST_FULL |-> rsp_entry_count == CNT_BITS'(CAPACITY))
    else $error("full status with room left");

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == ST_EMPTY |-> rsp_entry_count == '0
      && rsp_popped_value == '0)
    else $error("empty status with entries held or nonzero word");

endmodule

bind double_ended_queue deq_checker #(
  .CAPACITY (CAPACITY)
) u_deq_checker (
  .clk              (clk),
  .rst              (rst),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_status       (rsp.status),
  .rsp_popped_value (rsp.popped_value),
  .rsp_entry_count  (rsp.entry_count)
);
